FILE: sv/ffhtd_pkg.sv
// Package for the fixed frame header/trailer deframer.
// Holds default sizes, register reset values, register indexes and the FSM type.
// No dependencies.
package ffhtd_pkg;

    // Default payload length of one frame, in bytes
    localparam int PAYLOAD_BYTES_DEF = 8;

    // Byte width of the stream
    localparam int BYTE_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER = 1'b1;

    localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hA5;
    localparam logic [BYTE_W-1:0] TRAILER_RESET = 8'h5A;

    typedef enum logic {
        ST_FILL,
        ST_EMIT
    } t_state;

endpackage

FILE: sv/ffhtd_rx_if.sv
// Receive byte channel of the deframer.
// Uses ffhtd_pkg for the byte width.
interface ffhtd_rx_if;
    logic                         valid;
    logic                         ready;
    logic [ffhtd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/ffhtd_pl_if.sv
// Payload output channel of the deframer.
// Uses ffhtd_pkg for the byte width.
interface ffhtd_pl_if;
    logic                         valid;
    logic                         ready;
    logic [ffhtd_pkg::BYTE_W-1:0] payload_byte;
    logic                         last_of_frame;

    modport source (output valid, output payload_byte, output last_of_frame, input ready);
    modport sink   (input valid, input payload_byte, input last_of_frame, output ready);
endinterface

FILE: sv/fixed_frame_header_trailer_deframer.sv
// Top level of the fixed-length header/trailer deframer.
// Depends on ffhtd_pkg, ffhtd_rx_if and ffhtd_pl_if.
//
//  channel   dir  beat payload                  role
//  -------   ---  ------------------------  ---------------------------------
//  i_rx      in   rx_byte[7:0]              received serial bytes
//  o_pl      out  payload_byte[7:0], last   payload bytes of checked frames
//  i_cfg_*   in   idx, data[7:0]            header / trailer byte registers
//
//  Receive beats are taken one per cycle while the window fills or slides.
//  A matching frame then streams PAYLOAD_BYTES beats out, one per cycle while
//  o_pl is ready, from the registered read port of the window memory; receive
//  is held off meanwhile. Output stalls hold the emit counter and the read
//  address.
//  Synchronous active-low reset clears fill, ring head, emit count and FSM and
//  loads header/trailer defaults; the window memory itself needs no clearing.
module fixed_frame_header_trailer_deframer #(
    parameter int PAYLOAD_BYTES = ffhtd_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ffhtd_rx_if.sink                         i_rx,
    ffhtd_pl_if.source                       o_pl,
    input  logic                             i_cfg_we,
    input  logic [ffhtd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ffhtd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FRAME = PAYLOAD_BYTES + 2;
    localparam int AW    = $clog2(FRAME);
    localparam int CW    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    localparam logic [AW:0]   FRAME_W   = (AW+1)'(FRAME);
    localparam logic [AW-1:0] FULL_FILL = AW'(FRAME - 1);
    localparam logic [CW-1:0] LAST_CNT  = CW'(PAYLOAD_BYTES - 1);

    // Window memory: a ring of FRAME bytes, oldest byte at r_head
    logic [ffhtd_pkg::BYTE_W-1:0] r_mem [FRAME];
    logic [ffhtd_pkg::BYTE_W-1:0] r_rd;

    logic [ffhtd_pkg::BYTE_W-1:0] r_header;
    logic [ffhtd_pkg::BYTE_W-1:0] r_trailer;

    ffhtd_pkg::t_state r_state, n_state;
    logic [AW-1:0]     r_head,  n_head;
    logic [AW-1:0]     r_fill,  n_fill;
    logic [CW-1:0]     r_cnt,   n_cnt;

    logic          rx_acc;
    logic          pl_acc;
    logic          full_now;
    logic          frame_ok;
    logic          last_beat;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] head_inc;

    // Fold a sum below 2*FRAME back into the ring
    function automatic logic [AW-1:0] ring_wrap(input logic [AW:0] s);
        logic [AW:0] r;
        r = (s >= FRAME_W) ? (s - FRAME_W) : s;
        return r[AW-1:0];
    endfunction

    assign rx_acc    = i_rx.valid & i_rx.ready;
    assign pl_acc    = o_pl.valid & o_pl.ready;
    assign last_beat = (r_cnt == LAST_CNT);

    // The incoming byte completes the window when fill is one short
    assign full_now = (r_fill == FULL_FILL);
    // r_rd always holds the oldest byte while filling
    assign frame_ok = (r_rd == r_header) && (i_rx.rx_byte == r_trailer);

    assign wr_addr  = ring_wrap({1'b0, r_head} + {1'b0, r_fill});
    assign head_inc = ring_wrap({1'b0, r_head} + (AW+1)'(1));

    //------------------------------------------------------------------
    // Next state
    //------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffhtd_pkg::ST_FILL: begin
                if (rx_acc && full_now && frame_ok) begin
                    n_state = ffhtd_pkg::ST_EMIT;
                end
            end
            ffhtd_pkg::ST_EMIT: begin
                if (pl_acc && last_beat) begin
                    n_state = ffhtd_pkg::ST_FILL;
                end
            end
            default: n_state = ffhtd_pkg::ST_FILL;
        endcase
    end

    //------------------------------------------------------------------
    // Handshake outputs
    //------------------------------------------------------------------
    always_comb begin
        i_rx.ready = 1'b0;
        o_pl.valid = 1'b0;
        unique case (r_state)
            ffhtd_pkg::ST_FILL: i_rx.ready = 1'b1;
            ffhtd_pkg::ST_EMIT: o_pl.valid = 1'b1;
            default: begin
                i_rx.ready = 1'b0;
                o_pl.valid = 1'b0;
            end
        endcase
    end

    // Payload comes straight off the registered memory read
    assign o_pl.payload_byte  = r_rd;
    assign o_pl.last_of_frame = last_beat;

    //------------------------------------------------------------------
    // Window bookkeeping
    //------------------------------------------------------------------
    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        n_cnt  = r_cnt;
        if (rx_acc) begin
            if (!full_now) begin
                n_fill = r_fill + AW'(1);
            end else if (frame_ok) begin
                // Good frame: start emitting, window will be empty after it
                n_fill = '0;
                n_cnt  = '0;
            end else begin
                // Drop the oldest byte, keep sliding
                n_head = head_inc;
            end
        end
        if (pl_acc && !last_beat) begin
            n_cnt = r_cnt + CW'(1);
        end
    end

    // Look ahead to the next state: fetch the oldest byte, or the next payload byte
    always_comb begin
        if (n_state == ffhtd_pkg::ST_EMIT) begin
            rd_addr = ring_wrap({1'b0, r_head} + (AW+1)'(1) + (AW+1)'(n_cnt));
        end else begin
            rd_addr = n_head;
        end
    end

    //------------------------------------------------------------------
    // Window memory, one write and one registered read port
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (rx_acc) begin
            r_mem[wr_addr] <= i_rx.rx_byte;
        end
    end

    // Forward a byte written to the entry being read (empty window case)
    always_ff @(posedge i_clk) begin
        if (rx_acc && (wr_addr == rd_addr)) begin
            r_rd <= i_rx.rx_byte;
        end else begin
            r_rd <= r_mem[rd_addr];
        end
    end

    //------------------------------------------------------------------
    // Control registers
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffhtd_pkg::ST_FILL;
            r_head  <= '0;
            r_fill  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= ffhtd_pkg::HEADER_RESET;
            r_trailer <= ffhtd_pkg::TRAILER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ffhtd_pkg::CFG_HEADER:  r_header  <= i_cfg_data;
                ffhtd_pkg::CFG_TRAILER: r_trailer <= i_cfg_data;
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_FILL)
        else $error("window fill beyond frame size");

    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_acc && full_now && frame_ok) |=>
            (r_state == ffhtd_pkg::ST_EMIT) && (r_cnt == '0) && (r_fill == '0))
        else $error("good frame did not start emission");

    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pl_acc && last_beat) |=> (r_state == ffhtd_pkg::ST_FILL) && (r_fill == '0))
        else $error("frame end did not return to an empty window");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffhtd_pkg::ST_EMIT && !o_pl.ready) |=>
            ($stable(r_cnt) && $stable(r_head)))
        else $error("emit position moved during stall");

endmodule
